@@ sv/q8k_pkg.sv @@
// ----------------------------------------------------------------------------
// q8k_pkg
// Shared constants and controller/datapath interface types of the q8k block
// quantizer.
// ----------------------------------------------------------------------------
package q8k_pkg;

	localparam int BLOCK_LEN = 256;
	localparam int GROUP_LEN = 16;
	localparam int CNT_W     = $clog2(BLOCK_LEN);
	localparam int GRP_W     = $clog2(GROUP_LEN);

	localparam logic [7:0]  FP_EXP_MAX = 8'hFF;
	localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;

	// controller to datapath
	typedef struct packed {
		logic accept;      // sample transfer this cycle
		logic div_go;      // launch a division
		logic div_second;  // 1: d = 1/inv, 0: inv = -127/peak
		logic rd_go;       // read next stored sample into the code pipe
		logic blk_clear;   // block done: clear peak
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_sample; // write pointer at the final slot of a block
		logic div_done;
		logic rd_last;     // read pointer at the final slot
		logic blk_done;    // final result of the block is on the ports
	} dp_sts_t;

endpackage

@@ sv/q8k_fdiv.sv @@
// ----------------------------------------------------------------------------
// q8k_fdiv
// Iterative single-precision divider for a constant dividend (-127.0 or 1.0):
// normalizes the divisor one bit a cycle, then one quotient bit a cycle,
// then rounds to nearest even with gradual underflow and overflow to inf.
// ----------------------------------------------------------------------------
module q8k_fdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic        a_one,
	input  logic [31:0] b_bits,
	output logic        done,
	output logic [31:0] q_bits
);
	import q8k_pkg::*;

	localparam logic [2:0] DV_IDLE  = 3'd0;
	localparam logic [2:0] DV_NORM  = 3'd1;
	localparam logic [2:0] DV_ITER  = 3'd2;
	localparam logic [2:0] DV_ROUND = 3'd3;
	localparam logic [2:0] DV_DONE  = 3'd4;

	logic [2:0]         st_q;
	logic [23:0]        mb_q;
	logic signed [9:0]  eb_q;
	logic signed [9:0]  ea_q;
	logic [24:0]        rem_q;
	logic [26:0]        quo_q;
	logic [4:0]         cnt_q;
	logic               sgn_q;
	logic [31:0]        res_q;

	logic               ge;
	logic [24:0]        rem_sub;
	logic signed [10:0] e_base;
	logic signed [10:0] lead;
	logic signed [10:0] te;
	logic signed [10:0] s_sub;
	logic               normal;
	logic [4:0]         sh;
	logic [31:0]        quo32;
	logic [31:0]        mant;
	logic [31:0]        below_mask;
	logic               grd;
	logic               rst_bits;
	logic               rinc;
	logic [24:0]        rmant;
	logic [10:0]        be;
	logic [33:0]        total;
	logic [31:0]        rounded;

	assign ge      = rem_q >= {1'b0, mb_q};
	assign rem_sub = ge ? (rem_q - {1'b0, mb_q}) : rem_q;

	always_comb begin
		e_base     = 11'(ea_q) - 11'(eb_q) - 11'sd26;
		lead       = quo_q[26] ? 11'sd26 : 11'sd25;
		te         = lead + e_base;
		normal     = te >= -11'sd126;
		s_sub      = -11'sd149 - e_base;
		if (normal)
			sh = 5'(lead - 11'sd23);
		else if (s_sub > 11'sd31)
			sh = 5'd31;
		else
			sh = 5'(s_sub);
		quo32      = {5'b0, quo_q};
		mant       = quo32 >> sh;
		grd        = (sh == 5'd0) ? 1'b0 : quo32[sh - 5'd1];
		below_mask = (sh == 5'd0) ? 32'd0 : ((32'd1 << (sh - 5'd1)) - 32'd1);
		rst_bits   = (|(quo32 & below_mask)) | (|rem_q);
		rinc       = grd & (rst_bits | mant[0]);
		rmant      = mant[24:0] + {24'b0, rinc};
		be         = normal ? 11'(te + 11'sd126) : 11'd0;
		total      = {be, 23'b0} + {9'b0, rmant};
		if (total >= {3'b0, FP_INF_MAG})
			rounded = {sgn_q, FP_INF_MAG};
		else
			rounded = {sgn_q, total[30:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DV_IDLE;
		end else begin
			case (st_q)
				DV_IDLE: begin
					if (go) begin
						if (b_bits[30:23] == FP_EXP_MAX || b_bits[30:0] == 31'd0)
							st_q <= DV_DONE;
						else
							st_q <= DV_NORM;
					end
				end
				DV_NORM: begin
					if (mb_q[23])
						st_q <= DV_ITER;
				end
				DV_ITER: begin
					if (cnt_q == 5'd0)
						st_q <= DV_ROUND;
				end
				DV_ROUND: st_q <= DV_DONE;
				DV_DONE:  st_q <= DV_IDLE;
				default:  st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				sgn_q <= ~a_one ^ b_bits[31];
				ea_q  <= a_one ? 10'sd0 : 10'sd6;
				rem_q <= a_one ? 25'h080_0000 : 25'h0FE_0000;
				quo_q <= 27'd0;
				cnt_q <= 5'd26;
				if (b_bits[30:23] == FP_EXP_MAX)
					res_q <= {~a_one ^ b_bits[31], 31'd0};
				else
					res_q <= {~a_one ^ b_bits[31], FP_INF_MAG};
				if (b_bits[30:23] == 8'd0) begin
					mb_q <= {1'b0, b_bits[22:0]};
					eb_q <= -10'sd126;
				end else begin
					mb_q <= {1'b1, b_bits[22:0]};
					eb_q <= 10'(b_bits[30:23]) - 10'sd127;
				end
			end
			DV_NORM: begin
				if (!mb_q[23]) begin
					mb_q <= {mb_q[22:0], 1'b0};
					eb_q <= eb_q - 10'sd1;
				end
			end
			DV_ITER: begin
				quo_q <= {quo_q[25:0], ge};
				rem_q <= {rem_sub[23:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			DV_ROUND: res_q <= rounded;
			default: ;
		endcase
	end

	assign done   = st_q == DV_DONE;
	assign q_bits = res_q;

endmodule

@@ sv/q8k_datapath.sv @@
// ----------------------------------------------------------------------------
// q8k_datapath
// Sample store, peak tracker, scale registers, code pipeline
// (read, multiply, align, round) and chunk packer.
// ----------------------------------------------------------------------------
module q8k_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  q8k_pkg::dp_cmd_t  cmd,
	output q8k_pkg::dp_sts_t  sts,
	input  logic [31:0]       sample_bits,
	output logic              strobe,
	output logic [63:0]       codes_packed,
	output logic [31:0]       scale_bits,
	output logic signed [11:0] group_sum,
	output logic              sum_valid,
	output logic [4:0]        chunk_index,
	output logic              block_last
);
	import q8k_pkg::*;

	logic [31:0] mem [BLOCK_LEN];

	logic [CNT_W-1:0] wr_cnt_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [31:0]      peak_sig_q;
	logic [30:0]      peak_mag_q;
	logic [31:0]      inv_q;
	logic [31:0]      d_q;

	logic        div_done;
	logic [31:0] div_q;

	// stage 1: stored sample
	logic        valid_s1;
	logic [31:0] x_s1;
	// stage 2: product
	logic               valid_s2;
	logic [47:0]        prod_s2;
	logic signed [9:0]  k_s2;
	logic               sgn_s2, zero_s2, clamp_s2;
	// stage 3: fixed-point value
	logic        valid_s3;
	logic [33:0] f_s3;
	logic        stk_s3, big_s3, sgn_s3, zero_s3, clamp_s3;

	// packer
	logic [CNT_W-1:0] out_cnt_q;
	logic [GRP_W-1:0] gcnt_q;
	logic signed [11:0] gsum_q;
	logic [63:0]      pack_q;
	logic             strobe_q, sum_valid_q, last_q;
	logic [63:0]      codes_q;
	logic signed [11:0] gsum_out_q;
	logic [4:0]       chunk_q;

	// ---------------- load side ----------------
	always_ff @(posedge clk) begin
		if (cmd.accept)
			mem[wr_cnt_q] <= sample_bits;
		if (cmd.rd_go)
			x_s1 <= mem[rd_cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q   <= '0;
			rd_cnt_q   <= '0;
			peak_sig_q <= '0;
			peak_mag_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_go;
			if (cmd.rd_go)
				rd_cnt_q <= rd_cnt_q + 1'b1;
			if (cmd.blk_clear) begin
				wr_cnt_q   <= '0;
				peak_sig_q <= '0;
				peak_mag_q <= '0;
			end else if (cmd.accept) begin
				wr_cnt_q <= wr_cnt_q + 1'b1;
				// NaN never wins; ties keep the earlier sample
				if (sample_bits[30:0] <= FP_INF_MAG && sample_bits[30:0] > peak_mag_q) begin
					peak_mag_q <= sample_bits[30:0];
					peak_sig_q <= sample_bits;
				end
			end
		end
	end

	q8k_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.a_one  (cmd.div_second),
		.b_bits (cmd.div_second ? inv_q : peak_sig_q),
		.done   (div_done),
		.q_bits (div_q)
	);

	// all-zero block: both scales are zero
	always_ff @(posedge clk) begin
		if (div_done) begin
			if (cmd.div_second)
				d_q <= (peak_mag_q == 31'd0) ? 32'd0 : div_q;
			else
				inv_q <= (peak_mag_q == 31'd0) ? 32'd0 : div_q;
		end
	end

	assign sts.last_sample = wr_cnt_q == CNT_W'(BLOCK_LEN - 1);
	assign sts.rd_last     = rd_cnt_q == CNT_W'(BLOCK_LEN - 1);
	assign sts.div_done    = div_done;
	assign sts.blk_done    = strobe_q & last_q;

	// ---------------- stage 1 -> 2: multiply ----------------
	logic [7:0]        iexp, xexp;
	logic [23:0]       mi, mx;
	logic signed [9:0] ei, ex;
	logic              x_nan, x_inf, x_zero, i_inf, i_zero;

	always_comb begin
		iexp   = inv_q[30:23];
		xexp   = x_s1[30:23];
		mi     = (iexp == 8'd0) ? {1'b0, inv_q[22:0]} : {1'b1, inv_q[22:0]};
		mx     = (xexp == 8'd0) ? {1'b0, x_s1[22:0]} : {1'b1, x_s1[22:0]};
		ei     = (iexp == 8'd0) ? -10'sd126 : (10'(iexp) - 10'sd127);
		ex     = (xexp == 8'd0) ? -10'sd126 : (10'(xexp) - 10'sd127);
		x_nan  = xexp == FP_EXP_MAX && x_s1[22:0] != 23'd0;
		x_inf  = xexp == FP_EXP_MAX && x_s1[22:0] == 23'd0;
		x_zero = x_s1[30:0] == 31'd0;
		i_inf  = iexp == FP_EXP_MAX;
		i_zero = inv_q[30:0] == 31'd0;
	end

	always_ff @(posedge clk) begin
		prod_s2  <= mi * mx;
		// weight of product bit 0, relative to 2^-26
		k_s2     <= ei + ex - 10'sd20;
		sgn_s2   <= inv_q[31] ^ x_s1[31];
		zero_s2  <= x_nan | (x_inf & i_zero) | (i_inf & x_zero);
		clamp_s2 <= (x_inf & ~i_zero) | (i_inf & ~x_zero & ~x_nan);
	end

	// ---------------- stage 2 -> 3: align to fixed point ----------------
	logic [9:0]   sh_raw;
	logic [129:0] wide;
	logic [33:0]  f_nxt;
	logic         stk_nxt, big_nxt;

	always_comb begin
		sh_raw  = 10'(k_s2 + 10'sd48);
		wide    = {82'b0, prod_s2} << sh_raw[6:0];
		f_nxt   = wide[81:48];
		stk_nxt = |wide[47:0];
		big_nxt = |wide[129:82];
		if (k_s2 > 10'sd33) begin
			f_nxt   = '0;
			stk_nxt = 1'b0;
			big_nxt = |prod_s2;
		end else if (k_s2 < -10'sd48) begin
			f_nxt   = '0;
			stk_nxt = |prod_s2;
			big_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		f_s3     <= f_nxt;
		stk_s3   <= stk_nxt;
		big_s3   <= big_nxt;
		sgn_s3   <= sgn_s2;
		zero_s3  <= zero_s2;
		clamp_s3 <= clamp_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// ---------------- stage 3: float round, then integer round ----------------
	logic        hit;
	logic [5:0]  lead;
	logic [3:0]  rsh;
	logic [34:0] fx, unit, lowm, rf;
	logic        lsb, grd, rst_bits, rinc;
	logic [8:0]  ip;
	logic        iinc;
	logic [9:0]  magi;
	logic [6:0]  mag7;
	logic [7:0]  code;

	always_comb begin
		hit  = 1'b0;
		lead = 6'd25;
		for (int i = 25; i <= 32; i++) begin
			if (f_s3[i]) begin
				hit  = 1'b1;
				lead = 6'(i);
			end
		end
		// product rounded to 24 significant bits first
		rsh      = 4'(lead - 6'd23);
		fx       = {1'b0, f_s3};
		unit     = 35'd1 << rsh;
		lowm     = unit - 35'd1;
		lsb      = |(fx & unit);
		grd      = |(fx & (unit >> 1));
		rst_bits = (|(fx & (lowm >> 1))) | stk_s3;
		rinc     = grd & (rst_bits | lsb);
		rf       = (fx & ~lowm) + (rinc ? unit : 35'd0);
		ip       = rf[34:26];
		iinc     = rf[25] & ((|rf[24:0]) | ip[0]);
		magi     = {1'b0, ip} + {9'b0, iinc};
		if (zero_s3)
			mag7 = 7'd0;
		else if (clamp_s3 || big_s3 || f_s3[33])
			mag7 = 7'd127;
		else if (!hit)
			mag7 = 7'd0;
		else if (magi > 10'd127)
			mag7 = 7'd127;
		else
			mag7 = magi[6:0];
		code = sgn_s3 ? (8'd0 - {1'b0, mag7}) : {1'b0, mag7};
	end

	// ---------------- packer ----------------
	logic [63:0]        pack_nxt;
	logic signed [11:0] gsum_nxt;
	logic               chunk_end, gdone;

	always_comb begin
		pack_nxt  = {code, pack_q[63:8]};
		gsum_nxt  = gsum_q + {{4{code[7]}}, code};
		chunk_end = out_cnt_q[2:0] == 3'd7;
		gdone     = gcnt_q == GRP_W'(GROUP_LEN - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			gcnt_q    <= '0;
			gsum_q    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= valid_s3 & chunk_end;
			if (valid_s3) begin
				out_cnt_q <= out_cnt_q + 1'b1;
				gcnt_q    <= gdone ? '0 : gcnt_q + 1'b1;
				gsum_q    <= gdone ? 12'sd0 : gsum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			pack_q <= pack_nxt;
			if (chunk_end) begin
				codes_q     <= pack_nxt;
				chunk_q     <= 5'(out_cnt_q >> 3);
				sum_valid_q <= gdone;
				gsum_out_q  <= gdone ? gsum_nxt : 12'sd0;
				last_q      <= out_cnt_q == CNT_W'(BLOCK_LEN - 1);
			end
		end
	end

	assign strobe       = strobe_q;
	assign codes_packed = codes_q;
	assign scale_bits   = d_q;
	assign group_sum    = gsum_out_q;
	assign sum_valid    = sum_valid_q;
	assign chunk_index  = chunk_q;
	assign block_last   = last_q;

endmodule

@@ sv/q8k_ctrl.sv @@
// ----------------------------------------------------------------------------
// q8k_ctrl
// Block sequencer: load samples, run the two scale divisions, stream the
// stored block through the code pipeline, wait for the final result.
// ----------------------------------------------------------------------------
module q8k_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output q8k_pkg::dp_cmd_t cmd,
	input  q8k_pkg::dp_sts_t sts
);
	import q8k_pkg::*;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_DIV1  = 3'd1;
	localparam logic [2:0] ST_WAIT1 = 3'd2;
	localparam logic [2:0] ST_DIV2  = 3'd3;
	localparam logic [2:0] ST_WAIT2 = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;

	logic [2:0] st_q;
	logic [2:0] st_nxt;

	always_comb begin
		cmd    = '0;
		st_nxt = st_q;
		case (st_q)
			ST_LOAD: begin
				cmd.accept = start;
				if (start && sts.last_sample)
					st_nxt = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_go = 1'b1;
				st_nxt     = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (sts.div_done)
					st_nxt = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_go     = 1'b1;
				cmd.div_second = 1'b1;
				st_nxt         = ST_WAIT2;
			end
			ST_WAIT2: begin
				cmd.div_second = 1'b1;
				if (sts.div_done)
					st_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.rd_go = 1'b1;
				if (sts.rd_last)
					st_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.blk_done) begin
					cmd.blk_clear = 1'b1;
					st_nxt        = ST_LOAD;
				end
			end
			default: st_nxt = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_LOAD;
		else
			st_q <= st_nxt;
	end

	assign busy = st_q != ST_LOAD;

endmodule

@@ sv/q8k_block_quantizer_unit.sv @@
// ----------------------------------------------------------------------------
// q8k_block_quantizer_unit
// Operation: 256 sample transfers at up to one per cycle, then busy for two
//   scale divisions (27-bit quotient iteration, after normalization for a subnormal
//   peak), 256 store reads and the code pipeline (read, multiply, align, round).
// Output: 32 results per block, one per eight stored samples during the read pass;
//   samples of the next block are taken only while not busy. Results cannot be
//   stalled.
// Reset: arst_n clears the sequencer, counters and peak; store is not cleared.
// ----------------------------------------------------------------------------
module q8k_block_quantizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        sample_bits,
	output logic               strobe,
	output logic [63:0]        codes_packed,
	output logic [31:0]        scale_bits,
	output logic signed [11:0] group_sum,
	output logic               sum_valid,
	output logic [4:0]         chunk_index,
	output logic               block_last
);
	import q8k_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	q8k_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	q8k_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample_bits  (sample_bits),
		.strobe       (strobe),
		.codes_packed (codes_packed),
		.scale_bits   (scale_bits),
		.group_sum    (group_sum),
		.sum_valid    (sum_valid),
		.chunk_index  (chunk_index),
		.block_last   (block_last)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result strobe outside busy window");

	a_last_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && block_last |-> chunk_index == 5'(BLOCK_LEN / 8 - 1))
		else $error("block_last on wrong chunk");

	a_sum_odd: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && sum_valid |-> chunk_index[0])
		else $error("group sum on an even chunk");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a sample transfer");

endmodule

@@ dv/q8k_block_quantizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// q8k_block_quantizer_unit_tb
// Self-checking bench for the q8k block quantizer. Sends blocks of single-
// precision samples (a tie and rounding block, and an infinite peak block
// with NaN, negative zero and subnormal samples) with random gaps on start,
// and predicts each block's scale, packed codes and group sums with correctly
// rounded single-precision arithmetic.
// Every strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module q8k_block_quantizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import q8k_pkg::*;

	localparam int CHUNKS = BLOCK_LEN / 8;

	typedef struct {
		logic [63:0] codes;
		logic [31:0] scale;
		logic [11:0] gsum;
		logic        gvalid;
		logic [4:0]  idx;
		logic        last;
	} chunk_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [31:0]        sample_bits = '0;
	logic               busy;
	logic               strobe;
	logic [63:0]        codes_packed;
	logic [31:0]        scale_bits;
	logic signed [11:0] group_sum;
	logic               sum_valid;
	logic [4:0]         chunk_index;
	logic               block_last;

	q8k_block_quantizer_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_bits(sample_bits), .strobe(strobe), .codes_packed(codes_packed),
		.scale_bits(scale_bits), .group_sum(group_sum), .sum_valid(sum_valid),
		.chunk_index(chunk_index), .block_last(block_last)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] held_samples[BLOCK_LEN];
	logic [31:0] peak_bits;
	logic [30:0] peak_mag;
	int          fill_count;

	chunk_t      expected_chunks[$];
	int          mismatches;
	int          blocks_sent;
	int          chunks_seen;
	bit          burst_mode;
	logic [31:0] blk[BLOCK_LEN];

	function automatic real f32_to_real(logic [31:0] f);
		logic [7:0]  e;
		logic [23:0] m;
		int          ex;
		logic [10:0] e64;
		e = f[30:23];
		m = {1'b0, f[22:0]};
		if (e == 8'hFF)
			return $bitstoreal({f[31], 11'h7FF, (m != 0) ? 52'h8_0000_0000_0000 : 52'h0});
		if (e == 8'h00) begin
			if (m == 0)
				return $bitstoreal({f[31], 63'h0});
			ex = -126;
			while (!m[23]) begin
				m = m << 1;
				ex--;
			end
			e64 = 11'(ex + 1023);
			return $bitstoreal({f[31], e64, m[22:0], 29'h0});
		end
		e64 = 11'(int'(e) - 127 + 1023);
		return $bitstoreal({f[31], e64, m[22:0], 29'h0});
	endfunction

	// round a double to single precision, half to even, with subnormals
	function automatic logic [31:0] real_to_f32(real r);
		logic [63:0] b;
		logic [63:0] sig, q, rem, half;
		int          ex, shift;
		b = $realtobits(r);
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 0) ? 32'h7FC0_0000 : {b[63], 8'hFF, 23'h0};
		if (b[62:52] == 11'h0)
			return {b[63], 31'h0};
		ex = int'(b[62:52]) - 1023;
		sig = {11'h0, 1'b1, b[51:0]};
		shift = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (shift >= 55)
			return {b[63], 31'h0};
		q = sig >> shift;
		rem = sig & ((64'd1 << shift) - 1);
		half = 64'd1 << (shift - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		if (ex >= -126) begin
			if (q[24]) begin
				q = q >> 1;
				ex++;
			end
			if (ex > 127)
				return {b[63], 8'hFF, 23'h0};
			return {b[63], 8'(ex + 127), q[22:0]};
		end
		return {b[63], q[30:0]};
	endfunction

	function automatic int code_of(logic [31:0] inv, logic [31:0] x);
		bit  inv_inf, inv_zero, x_inf, x_zero;
		real v, fl;
		inv_inf = inv[30:0] == 31'h7F80_0000;
		inv_zero = inv[30:0] == 31'h0;
		x_inf = x[30:0] == 31'h7F80_0000;
		x_zero = x[30:0] == 31'h0;
		if (x[30:0] > 31'h7F80_0000)
			return 0;
		if ((inv_inf && x_zero) || (inv_zero && x_inf))
			return 0;
		if (inv_inf || x_inf)
			return (inv[31] ^ x[31]) ? -127 : 127;
		v = f32_to_real(real_to_f32(f32_to_real(inv) * f32_to_real(x)));
		if (v > 127.0)
			v = 127.0;
		if (v < -127.0)
			v = -127.0;
		fl = $floor(v);
		if (v - fl > 0.5 || (v - fl == 0.5 && (int'(fl) % 2 != 0)))
			fl = fl + 1.0;
		return int'(fl);
	endfunction

	// fold one accepted sample in; on the final sample queue the block's chunks
	task automatic quantize_sample(logic [31:0] s);
		logic [31:0] inv, d;
		int          acc, c, k, code;
		chunk_t      ch;
		held_samples[fill_count] = s;
		if (s[30:0] <= FP_INF_MAG && s[30:0] > peak_mag) begin
			peak_mag = s[30:0];
			peak_bits = s;
		end
		fill_count++;
		if (fill_count < BLOCK_LEN)
			return;
		if (peak_mag == 0) begin
			inv = '0;
			d = '0;
		end else if (peak_mag == FP_INF_MAG) begin
			inv = {~peak_bits[31], 31'h0};
			d = {~peak_bits[31], 8'hFF, 23'h0};
		end else begin
			inv = real_to_f32(-127.0 / f32_to_real(peak_bits));
			if (inv[30:0] == FP_INF_MAG)
				d = {inv[31], 31'h0};
			else
				d = real_to_f32(1.0 / f32_to_real(inv));
		end
		acc = 0;
		for (c = 0; c < CHUNKS; c++) begin
			ch.codes = '0;
			for (k = 0; k < 8; k++) begin
				code = code_of(inv, held_samples[c*8 + k]);
				acc += code;
				ch.codes[8*k +: 8] = 8'(code);
			end
			ch.gvalid = (((c + 1) * 8) % GROUP_LEN) == 0;
			ch.gsum = ch.gvalid ? 12'(acc) : 12'h0;
			ch.scale = d;
			ch.idx = 5'(c);
			ch.last = c == CHUNKS - 1;
			if (ch.gvalid)
				acc = 0;
			expected_chunks.push_back(ch);
		end
		fill_count = 0;
		peak_bits = '0;
		peak_mag = '0;
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH t=%0t chunk %0d: %s", $realtime, chunk_index, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		chunk_t e;
		if (arst_n && strobe) begin
			chunks_seen++;
			if (expected_chunks.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = expected_chunks.pop_front();
				if (codes_packed !== e.codes)
					report_mismatch($sformatf("codes %h exp %h", codes_packed, e.codes));
				if (scale_bits !== e.scale)
					report_mismatch($sformatf("scale %h exp %h", scale_bits, e.scale));
				if (group_sum !== e.gsum)
					report_mismatch($sformatf("group_sum %0d exp %0d", group_sum,
						$signed(e.gsum)));
				if (sum_valid !== e.gvalid)
					report_mismatch($sformatf("sum_valid %b exp %b", sum_valid, e.gvalid));
				if (chunk_index !== e.idx)
					report_mismatch($sformatf("chunk_index %0d exp %0d", chunk_index, e.idx));
				if (block_last !== e.last)
					report_mismatch($sformatf("block_last %b exp %b", block_last, e.last));
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// present one sample and hold it until the transfer
	task automatic send_sample(logic [31:0] s);
		int gap;
		start <= 1'b1;
		sample_bits <= s;
		do
			@(posedge clk);
		while (busy);
		quantize_sample(s);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_block();
		burst_mode = $urandom_range(0, 3) == 0;
		for (int i = 0; i < BLOCK_LEN; i++)
			send_sample(blk[i]);
		blocks_sent++;
	endtask

	function automatic logic [31:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
		if (r < 80)
			return $urandom;
		if (r < 90)
			return real_to_f32(real'($urandom_range(0, 400)) / 4.0 - 50.0);
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return {1'($urandom), 31'($urandom_range(1, 8))};
			default: return {1'($urandom), 8'hFE, 23'($urandom)};
		endcase
	endfunction

	// peak 127 gives inv = -1, so the half steps hit exact ties
	task automatic test_rounding_and_ties();
		for (int i = 0; i < BLOCK_LEN; i++)
			blk[i] = real_to_f32(real'(i % 64) * 0.5 - 16.0);
		blk[3] = 32'h42FE_0000;
		blk[9] = 32'hC2FE_0000;
		blk[20] = 32'h8000_0000;
		send_block();
	endtask

	task automatic test_infinite_peak();
		for (int i = 0; i < BLOCK_LEN; i++)
			blk[i] = rand_sample();
		blk[0] = 32'h0000_0000;
		blk[2] = 32'h7FC0_0001;
		blk[4] = 32'hFF80_0000;
		blk[8] = 32'h7F80_0000;
		blk[12] = 32'h8000_0000;
		send_block();
	endtask

	initial begin
		#2_000_000;
		$display("q8k_block_quantizer_unit verification failed");
		$finish;
	end

	initial begin
		mismatches = 0;
		blocks_sent = 0;
		chunks_seen = 0;
		fill_count = 0;
		peak_bits = '0;
		peak_mag = '0;
		burst_mode = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rounding_and_ties();
		test_infinite_peak();
		start <= 1'b0;
		wait (expected_chunks.size() == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d blocks (ties and rounding, infinite peak with NaN and zeros);",
			blocks_sent);
		$display("checked %0d strobed chunks.", chunks_seen);
		if (mismatches == 0 && expected_chunks.size() == 0)
			$display("q8k_block_quantizer_unit verification clean");
		else
			$display("q8k_block_quantizer_unit verification failed");
		$finish;
	end

endmodule
